/* rtl/dtfq_pkg.sv */
// shared constants and codes of the deferred transmit frame queue
// no dependencies
package dtfq_pkg;

    localparam int DTFQ_QUEUE_DEPTH = 8;
    localparam int DTFQ_FRAME_MAX   = 64;

    typedef enum logic [1:0] {
        CMD_BYTE   = 2'd0,
        CMD_POLL   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_STATUS = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_NONE     = 2'd0,
        STAT_QUEUED   = 2'd1,
        STAT_OVERSIZE = 2'd2,
        STAT_FULL     = 2'd3
    } commit_t;

endpackage

/* rtl/dtfq_ram.sv */
// generic single-clock ram, one write port and one registered read port
// no dependencies
module dtfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/deferred_tx_frame_queue.sv */
// top level of the deferred transmit frame queue: frame assembly, ring control,
// statistics counters and the byte sequencer; uses dtfq_pkg and dtfq_ram
//
// latency: a non-sending item gives its single result in the cycle after it is accepted
// throughput: one non-sending item per cycle unless the result output stalls; a poll that
// sends a frame holds the input off for the whole send, its bytes going out one per cycle
// unless the output stalls, paced by the single read port of the frame memory
// reset: synchronous active-low aresetn clears slots, counts, flags and counters;
// frame memory and length table are not cleared (read only after written)
module deferred_tx_frame_queue
    import dtfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DTFQ_QUEUE_DEPTH,
    parameter int FRAME_MAX   = DTFQ_FRAME_MAX
) (
    input  logic        aclk,
    input  logic        aresetn,
    // item input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_frame_byte,
    input  logic        s_frame_end,
    input  logic        s_aux_ready,
    input  logic        s_link_busy,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_byte_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_tx_last,
    output logic        m_ready_res,
    output logic [1:0]  m_commit_status,
    output logic [6:0]  m_pending_frames,
    output logic [31:0] m_deferred_count,
    output logic [31:0] m_sent_count,
    output logic [31:0] m_full_drops,
    output logic [31:0] m_oversize_drops
);

    // slot and in-frame offset widths; memory address is {slot, offset}
    localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OFF_W     = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
    localparam int FILL_W    = $clog2(FRAME_MAX + 1);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH = 1 << (SLOT_W + OFF_W);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    // sequencer and output register
    state_t            state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    logic              byte_valid_reg, byte_valid_next;
    logic [7:0]        tx_byte_reg, tx_byte_next;
    logic              tx_last_reg, tx_last_next;
    logic              ready_res_reg, ready_res_next;
    commit_t           status_reg, status_next;

    // ring control
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [CNT_W-1:0]  frame_count_reg, frame_count_next;
    logic [FILL_W-1:0] fill_length_reg, fill_length_next;
    logic              overflow_reg, overflow_next;
    logic              lost_reg, lost_next;

    // statistics
    logic [31:0]       deferred_reg, deferred_next;
    logic [31:0]       sent_reg, sent_next;
    logic [31:0]       full_reg, full_next;
    logic [31:0]       oversize_reg, oversize_next;

    // send sequencer: slot being sent, its length, next offset to read,
    // and whether the ram read register holds a byte not yet emitted
    logic [SLOT_W-1:0] send_slot_reg, send_slot_next;
    logic [FILL_W-1:0] send_len_reg, send_len_next;
    logic [FILL_W-1:0] rd_ofs_reg, rd_ofs_next;
    logic              pend_reg, pend_next;

    // frame length table, one entry per slot
    logic [FILL_W-1:0] len_mem [QUEUE_DEPTH];
    logic              len_we;

    // frame memory ports
    logic                    ram_we;
    logic [SLOT_W+OFF_W-1:0] ram_waddr;
    logic                    ram_re;
    logic [SLOT_W+OFF_W-1:0] ram_raddr;
    logic [7:0]              ram_rdata;

    logic              out_free;
    logic              accept;
    logic              queue_full;
    logic              can_send;
    logic [FILL_W-1:0] fill_inc;
    logic              emit;
    logic              issue;
    logic              single;

    dtfq_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_frame_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE) && out_free;
    assign accept     = s_valid && s_ready;
    assign queue_full = (frame_count_reg >= CNT_W'(QUEUE_DEPTH));
    assign can_send   = (frame_count_reg != '0) && s_aux_ready && !s_link_busy;
    assign fill_inc   = fill_length_reg + 1'b1;

    assign ram_waddr = {write_slot_reg, fill_length_reg[OFF_W-1:0]};
    assign ram_raddr = {send_slot_reg, rd_ofs_reg[OFF_W-1:0]};

    // the pending byte sits at offset rd_ofs-1, so it is last when rd_ofs reaches len
    assign emit  = (state_reg == ST_SEND) && pend_reg && out_free;
    assign issue = (state_reg == ST_SEND) && (rd_ofs_reg < send_len_reg)
                   && (!pend_reg || emit);
    assign ram_re = issue;

    always_comb begin
        state_next       = state_reg;
        m_valid_next     = m_valid_reg;
        byte_valid_next  = byte_valid_reg;
        tx_byte_next     = tx_byte_reg;
        tx_last_next     = tx_last_reg;
        ready_res_next   = ready_res_reg;
        status_next      = status_reg;
        write_slot_next  = write_slot_reg;
        read_slot_next   = read_slot_reg;
        frame_count_next = frame_count_reg;
        fill_length_next = fill_length_reg;
        overflow_next    = overflow_reg;
        lost_next        = lost_reg;
        deferred_next    = deferred_reg;
        sent_next        = sent_reg;
        full_next        = full_reg;
        oversize_next    = oversize_reg;
        send_slot_next   = send_slot_reg;
        send_len_next    = send_len_reg;
        rd_ofs_next      = rd_ofs_reg;
        pend_next        = pend_reg;
        ram_we           = 1'b0;
        len_we           = 1'b0;
        single           = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    single      = 1'b1;
                    status_next = STAT_NONE;
                    unique case (cmd_t'(s_cmd))
                        CMD_BYTE: begin
                            // bytes past the maximum are not stored
                            if (fill_length_reg >= FILL_W'(FRAME_MAX)) begin
                                overflow_next = 1'b1;
                            end else begin
                                if (queue_full) begin
                                    lost_next = 1'b1;
                                end else begin
                                    ram_we = 1'b1;
                                end
                                fill_length_next = fill_inc;
                            end
                            if (s_frame_end) begin
                                if (overflow_next) begin
                                    oversize_next = oversize_reg + 32'd1;
                                    status_next   = STAT_OVERSIZE;
                                end else if (lost_next || queue_full) begin
                                    full_next   = full_reg + 32'd1;
                                    status_next = STAT_FULL;
                                end else begin
                                    len_we           = 1'b1;
                                    write_slot_next  =
                                        (write_slot_reg == SLOT_W'(QUEUE_DEPTH - 1)) ?
                                        '0 : write_slot_reg + 1'b1;
                                    frame_count_next = frame_count_reg + 1'b1;
                                    deferred_next    = deferred_reg + 32'd1;
                                    status_next      = STAT_QUEUED;
                                end
                                fill_length_next = '0;
                                overflow_next    = 1'b0;
                                lost_next        = 1'b0;
                            end
                        end
                        CMD_POLL: begin
                            if (can_send) begin
                                single           = 1'b0;
                                state_next       = ST_SEND;
                                send_slot_next   = read_slot_reg;
                                send_len_next    = len_mem[read_slot_reg];
                                rd_ofs_next      = '0;
                                pend_next        = 1'b0;
                                read_slot_next   =
                                    (read_slot_reg == SLOT_W'(QUEUE_DEPTH - 1)) ?
                                    '0 : read_slot_reg + 1'b1;
                                frame_count_next = frame_count_reg - 1'b1;
                                sent_next        = sent_reg + 32'd1;
                            end
                        end
                        CMD_CLEAR: begin
                            deferred_next = '0;
                            sent_next     = '0;
                            full_next     = '0;
                            oversize_next = '0;
                        end
                        CMD_STATUS: begin
                        end
                        default: begin
                        end
                    endcase
                    // ready seen after this item, held through a whole send
                    ready_res_next = (frame_count_next == '0) && s_aux_ready
                                     && !s_link_busy;
                    if (single) begin
                        m_valid_next    = 1'b1;
                        byte_valid_next = 1'b0;
                        tx_byte_next    = 8'd0;
                        tx_last_next    = 1'b1;
                    end
                end
            end
            ST_SEND: begin
                if (emit) begin
                    m_valid_next    = 1'b1;
                    byte_valid_next = 1'b1;
                    tx_byte_next    = ram_rdata;
                    tx_last_next    = (rd_ofs_reg == send_len_reg);
                    if (rd_ofs_reg == send_len_reg) begin
                        state_next = ST_IDLE;
                    end
                end
                if (issue) begin
                    rd_ofs_next = rd_ofs_reg + 1'b1;
                    pend_next   = 1'b1;
                end else if (emit) begin
                    pend_next = 1'b0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            write_slot_reg  <= '0;
            read_slot_reg   <= '0;
            frame_count_reg <= '0;
            fill_length_reg <= '0;
            overflow_reg    <= 1'b0;
            lost_reg        <= 1'b0;
            deferred_reg    <= '0;
            sent_reg        <= '0;
            full_reg        <= '0;
            oversize_reg    <= '0;
            pend_reg        <= 1'b0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            write_slot_reg  <= write_slot_next;
            read_slot_reg   <= read_slot_next;
            frame_count_reg <= frame_count_next;
            fill_length_reg <= fill_length_next;
            overflow_reg    <= overflow_next;
            lost_reg        <= lost_next;
            deferred_reg    <= deferred_next;
            sent_reg        <= sent_next;
            full_reg        <= full_next;
            oversize_reg    <= oversize_next;
            pend_reg        <= pend_next;
        end
        // payload, no reset needed
        byte_valid_reg <= byte_valid_next;
        tx_byte_reg    <= tx_byte_next;
        tx_last_reg    <= tx_last_next;
        ready_res_reg  <= ready_res_next;
        status_reg     <= status_next;
        send_slot_reg  <= send_slot_next;
        send_len_reg   <= send_len_next;
        rd_ofs_reg     <= rd_ofs_next;
    end

    // length table, written on commit
    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[write_slot_reg] <= fill_inc;
        end
    end

    // counters only change when an item is accepted, which needs the result slot free,
    // so the live values are those after the item being shown
    assign m_valid          = m_valid_reg;
    assign m_byte_valid     = byte_valid_reg;
    assign m_tx_byte        = tx_byte_reg;
    assign m_tx_last        = tx_last_reg;
    assign m_ready_res      = ready_res_reg;
    assign m_commit_status  = status_reg;
    assign m_pending_frames = 7'(frame_count_reg);
    assign m_deferred_count = deferred_reg;
    assign m_sent_count     = sent_reg;
    assign m_full_drops     = full_reg;
    assign m_oversize_drops = oversize_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("frame count beyond queue depth");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_length_reg <= FILL_W'(FRAME_MAX))
        else $error("fill length beyond frame maximum");

    a_pend_in_send: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> state_reg == ST_SEND)
        else $error("pending read byte outside a send");

    a_send_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_cmd == CMD_POLL && can_send)
        |=> (state_reg == ST_SEND) && !m_valid_reg && !pend_reg)
        else $error("send did not start cleanly");

    a_send_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && rd_ofs_reg == send_len_reg)
        |=> (state_reg == ST_IDLE) && m_valid_reg && tx_last_reg && byte_valid_reg)
        else $error("last sent byte not marked");
`endif

endmodule

/* dv/tb_deferred_tx_frame_queue.sv */
`timescale 1ns / 1ps
// self-checking testbench for deferred_tx_frame_queue: directed rows, then random frame traffic
// checked against an in-bench model of the frame ring; depends on rtl/dtfq_pkg.sv and the rtl
module tb_deferred_tx_frame_queue;
    import dtfq_pkg::*;

    localparam int QD          = DTFQ_QUEUE_DEPTH;
    localparam int FM          = DTFQ_FRAME_MAX;
    // cycles with no item accepted and no result taken before the run is declared hung;
    // the longest correct stretch comes from the receiver hold-off
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        cmd_t       cmd;
        logic [7:0] fb;
        logic       fe;
        logic       aux;
        logic       busy;
    } item_t;

    typedef struct {
        logic        bv;
        logic [7:0]  tx_byte;
        logic        last;
        logic        rdy;
        commit_t     status;
        logic [6:0]  queued;
        logic [31:0] deferred;
        logic [31:0] sent;
        logic [31:0] full_drops;
        logic [31:0] over_drops;
    } res_t;

    typedef struct {
        item_t it;
        bit    typed;
        res_t  want;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [7:0]  s_frame_byte;
    logic        s_frame_end;
    logic        s_aux_ready;
    logic        s_link_busy;
    logic        m_valid;
    logic        m_ready;
    logic        m_byte_valid;
    logic [7:0]  m_tx_byte;
    logic        m_tx_last;
    logic        m_ready_res;
    logic [1:0]  m_commit_status;
    logic [6:0]  m_pending_frames;
    logic [31:0] m_deferred_count;
    logic [31:0] m_sent_count;
    logic [31:0] m_full_drops;
    logic [31:0] m_oversize_drops;

    deferred_tx_frame_queue dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_frame_byte     (s_frame_byte),
        .s_frame_end      (s_frame_end),
        .s_aux_ready      (s_aux_ready),
        .s_link_busy      (s_link_busy),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_valid     (m_byte_valid),
        .m_tx_byte        (m_tx_byte),
        .m_tx_last        (m_tx_last),
        .m_ready_res      (m_ready_res),
        .m_commit_status  (m_commit_status),
        .m_pending_frames (m_pending_frames),
        .m_deferred_count (m_deferred_count),
        .m_sent_count     (m_sent_count),
        .m_full_drops     (m_full_drops),
        .m_oversize_drops (m_oversize_drops)
    );

    // frame ring as the block should hold it
    logic [7:0]  frame_mem [QD*FM];
    int          frame_len [QD];
    int          wr_slot   = 0;
    int          rd_slot   = 0;
    int          held      = 0;
    int          fill_len  = 0;
    bit          too_long  = 0;
    bit          lost      = 0;
    logic [31:0] cnt_def   = '0;
    logic [31:0] cnt_sent  = '0;
    logic [31:0] cnt_full  = '0;
    logic [31:0] cnt_over  = '0;

    res_t  due_results [$];
    row_t  dir_rows    [$];
    int    mismatch_count = 0;
    int    result_count   = 0;
    int    items_sent     = 0;
    int    idle_run       = 0;
    int    src_gap_pct    = 0;
    int    rcv_idle_pct   = 0;
    bit    hold_off_req   = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic item_t item_of(cmd_t c, logic [7:0] b, logic e, logic a, logic k);
        item_t it;
        it.cmd  = c;
        it.fb   = b;
        it.fe   = e;
        it.aux  = a;
        it.busy = k;
        return it;
    endfunction

    function automatic res_t res_of(logic bv, logic [7:0] b, logic last, logic rdy,
                                    commit_t st, logic [6:0] q, logic [31:0] d,
                                    logic [31:0] s, logic [31:0] f, logic [31:0] o);
        res_t r;
        r.bv         = bv;
        r.tx_byte    = b;
        r.last       = last;
        r.rdy        = rdy;
        r.status     = st;
        r.queued     = q;
        r.deferred   = d;
        r.sent       = s;
        r.full_drops = f;
        r.over_drops = o;
        return r;
    endfunction

    // apply one accepted item to the ring and queue up the results it causes
    task automatic advance_frame_queue(input item_t it);
        commit_t st;
        int      slot;
        int      n;
        int      i;
        logic    rdy;
        st = STAT_NONE;
        case (it.cmd)
            CMD_BYTE: begin
                if (fill_len >= FM) begin
                    too_long = 1'b1;
                end else begin
                    // a byte that finds the ring full is lost, and so is its frame
                    if (held >= QD) lost = 1'b1;
                    else frame_mem[wr_slot*FM + fill_len] = it.fb;
                    fill_len++;
                end
                if (it.fe) begin
                    // oversize wins over full
                    if (too_long) begin
                        cnt_over++;
                        st = STAT_OVERSIZE;
                    end else if (lost || held >= QD) begin
                        cnt_full++;
                        st = STAT_FULL;
                    end else begin
                        frame_len[wr_slot] = fill_len;
                        wr_slot = (wr_slot + 1) % QD;
                        held++;
                        cnt_def++;
                        st = STAT_QUEUED;
                    end
                    fill_len = 0;
                    too_long = 1'b0;
                    lost     = 1'b0;
                end
            end
            CMD_POLL: begin
                if (held > 0 && it.aux && !it.busy) begin
                    slot    = rd_slot;
                    n       = frame_len[slot];
                    rd_slot = (rd_slot + 1) % QD;
                    held--;
                    cnt_sent++;
                    rdy = (held == 0);
                    for (i = 0; i < n; i++)
                        due_results.push_back(res_of(1'b1, frame_mem[slot*FM + i], i == n - 1,
                            rdy, STAT_NONE, 7'(held), cnt_def, cnt_sent, cnt_full, cnt_over));
                    return;
                end
            end
            CMD_CLEAR: begin
                cnt_def  = '0;
                cnt_sent = '0;
                cnt_full = '0;
                cnt_over = '0;
            end
            default: ;
        endcase
        rdy = (held == 0) && it.aux && !it.busy;
        due_results.push_back(res_of(1'b0, 8'h00, 1'b1, rdy, st, 7'(held),
                                     cnt_def, cnt_sent, cnt_full, cnt_over));
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("[%0t] result %0d: %s", $time, result_count, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, want %0h", name, got, want));
    endtask

    // offer one item, hold it until taken, then feed it to the model
    task automatic push_item(input item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= it.cmd;
        s_frame_byte <= it.fb;
        s_frame_end  <= it.fe;
        s_aux_ready  <= it.aux;
        s_link_busy  <= it.busy;
        do @(posedge aclk); while (!s_ready);
        advance_frame_queue(it);
        items_sent++;
    endtask

    // one frame of random bytes; mixed lets polls, clears and status queries slip in between
    task automatic send_frame(input int len, input bit mixed);
        int   i;
        int   pick;
        cmd_t c;
        for (i = 0; i < len; i++) begin
            if (mixed && $urandom_range(99) < 15) begin
                pick = $urandom_range(9);
                c = (pick == 0) ? CMD_CLEAR : (pick < 5) ? CMD_STATUS : CMD_POLL;
                push_item(item_of(c, 8'($urandom_range(255)), 1'($urandom_range(1)),
                                  $urandom_range(9) != 0, $urandom_range(4) == 0));
            end
            push_item(item_of(CMD_BYTE, 8'($urandom_range(255)), i == len - 1,
                              $urandom_range(9) != 0, $urandom_range(4) == 0));
        end
    endtask

    task automatic flush_queue();
        while (held > 0)
            push_item(item_of(CMD_POLL, 8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'b1, 1'b0));
    endtask

    // sender stops and waits for every outstanding result
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_mix(input int n);
        int   stop_at;
        int   r;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 55) begin
                // mostly short frames, now and then a longer one
                send_frame(($urandom_range(9) == 0) ? $urandom_range(7, 20)
                                                    : $urandom_range(1, 6), 1'b1);
            end else if (r < 85) begin
                push_item(item_of(CMD_POLL, 8'($urandom_range(255)), 1'($urandom_range(1)),
                                  $urandom_range(9) != 0, $urandom_range(4) == 0));
            end else if (r < 90) begin
                push_item(item_of(CMD_STATUS, 8'($urandom_range(255)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1))));
            end else if (r < 93) begin
                push_item(item_of(CMD_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1))));
            end else begin
                // noise: any command, any flags
                push_item(item_of(cmd_t'($urandom_range(3)), 8'($urandom_range(255)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)),
                                  1'($urandom_range(1))));
            end
        end
    endtask

    // receiver holds off while the ring fills; covers full at end and a byte lost while full
    task automatic overfill_queue();
        hold_off_req = 1'b1;
        while (held < QD)
            send_frame($urandom_range(1, 2), 1'b0);
        send_frame(2, 1'b0);
        push_item(item_of(CMD_BYTE, 8'($urandom_range(255)), 1'b0, 1'b1, 1'b0));
        // room appears, but the frame already lost a byte
        push_item(item_of(CMD_POLL, 8'h00, 1'b0, 1'b1, 1'b0));
        push_item(item_of(CMD_BYTE, 8'($urandom_range(255)), 1'b1, 1'b1, 1'b0));
        flush_queue();
    endtask

    task automatic add_row(input item_t it);
        row_t r;
        r.it    = it;
        r.typed = 1'b0;
        dir_rows.push_back(r);
    endtask

    task automatic add_checked(input item_t it, input res_t want);
        row_t r;
        r.it    = it;
        r.typed = 1'b1;
        r.want  = want;
        dir_rows.push_back(r);
    endtask

    // result side: random stalls, or a long hold-off when asked
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // result checker and hang watchdog
    always @(posedge aclk) begin
        res_t r;
        if (!aresetn) begin
            idle_run = 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_run = 0;
            else idle_run++;
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result arrived with nothing outstanding");
                end else begin
                    r = due_results.pop_front();
                    compare_field("byte_valid", 32'(m_byte_valid), 32'(r.bv));
                    compare_field("tx_byte", 32'(m_tx_byte), 32'(r.tx_byte));
                    compare_field("tx_last", 32'(m_tx_last), 32'(r.last));
                    compare_field("ready_res", 32'(m_ready_res), 32'(r.rdy));
                    compare_field("commit_status", 32'(m_commit_status), 32'(r.status));
                    compare_field("pending_frames", 32'(m_pending_frames), 32'(r.queued));
                    compare_field("deferred_count", m_deferred_count, r.deferred);
                    compare_field("sent_count", m_sent_count, r.sent);
                    compare_field("full_drops", m_full_drops, r.full_drops);
                    compare_field("oversize_drops", m_oversize_drops, r.over_drops);
                end
                result_count++;
            end
            if (idle_run >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int k;
        s_valid      = 1'b0;
        s_cmd        = CMD_BYTE;
        s_frame_byte = 8'h00;
        s_frame_end  = 1'b0;
        s_aux_ready  = 1'b0;
        s_link_busy  = 1'b0;
        aresetn      = 1'b0;

        // directed rows: ready combinations, polls that cannot send, interleaving, clear
        add_checked(item_of(CMD_STATUS, 8'h00, 1'b0, 1'b1, 1'b0),
            res_of(1'b0, 8'h00, 1'b1, 1'b1, STAT_NONE, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        add_checked(item_of(CMD_STATUS, 8'h00, 1'b0, 1'b0, 1'b0),
            res_of(1'b0, 8'h00, 1'b1, 1'b0, STAT_NONE, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        add_checked(item_of(CMD_STATUS, 8'hFF, 1'b1, 1'b1, 1'b1),
            res_of(1'b0, 8'h00, 1'b1, 1'b0, STAT_NONE, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        add_checked(item_of(CMD_POLL, 8'h00, 1'b0, 1'b1, 1'b0),
            res_of(1'b0, 8'h00, 1'b1, 1'b1, STAT_NONE, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        add_checked(item_of(CMD_BYTE, 8'h00, 1'b0, 1'b1, 1'b0),
            res_of(1'b0, 8'h00, 1'b1, 1'b1, STAT_NONE, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        add_row(item_of(CMD_STATUS, 8'h12, 1'b1, 1'b0, 1'b1));
        add_row(item_of(CMD_POLL, 8'h34, 1'b0, 1'b1, 1'b0));
        add_checked(item_of(CMD_CLEAR, 8'h00, 1'b0, 1'b1, 1'b0),
            res_of(1'b0, 8'h00, 1'b1, 1'b1, STAT_NONE, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        add_checked(item_of(CMD_BYTE, 8'hFF, 1'b1, 1'b1, 1'b0),
            res_of(1'b0, 8'h00, 1'b1, 1'b0, STAT_QUEUED, 7'd1, 32'd1, 32'd0, 32'd0, 32'd0));
        add_checked(item_of(CMD_POLL, 8'h00, 1'b0, 1'b0, 1'b0),
            res_of(1'b0, 8'h00, 1'b1, 1'b0, STAT_NONE, 7'd1, 32'd1, 32'd0, 32'd0, 32'd0));
        add_checked(item_of(CMD_POLL, 8'h00, 1'b0, 1'b1, 1'b1),
            res_of(1'b0, 8'h00, 1'b1, 1'b0, STAT_NONE, 7'd1, 32'd1, 32'd0, 32'd0, 32'd0));
        add_row(item_of(CMD_POLL, 8'h00, 1'b0, 1'b1, 1'b0));
        add_row(item_of(CMD_BYTE, 8'hA5, 1'b1, 1'b1, 1'b0));
        add_row(item_of(CMD_BYTE, 8'h5A, 1'b0, 1'b0, 1'b1));
        add_row(item_of(CMD_BYTE, 8'h3C, 1'b1, 1'b1, 1'b0));
        add_checked(item_of(CMD_CLEAR, 8'h00, 1'b0, 1'b1, 1'b0),
            res_of(1'b0, 8'h00, 1'b1, 1'b0, STAT_NONE, 7'd2, 32'd0, 32'd0, 32'd0, 32'd0));
        add_row(item_of(CMD_POLL, 8'h00, 1'b0, 1'b1, 1'b0));
        add_row(item_of(CMD_STATUS, 8'h00, 1'b0, 1'b1, 1'b0));
        add_row(item_of(CMD_POLL, 8'h00, 1'b0, 1'b1, 1'b0));
        add_row(item_of(CMD_POLL, 8'h00, 1'b0, 1'b1, 1'b0));
        add_row(item_of(CMD_BYTE, 8'h81, 1'b1, 1'b0, 1'b1));
        add_row(item_of(CMD_BYTE, 8'h7E, 1'b1, 1'b1, 1'b1));
        add_row(item_of(CMD_POLL, 8'h00, 1'b0, 1'b1, 1'b1));
        add_row(item_of(CMD_POLL, 8'h00, 1'b0, 1'b1, 1'b0));
        add_row(item_of(CMD_POLL, 8'h00, 1'b0, 1'b1, 1'b0));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // phase 1: sender seldom idles, receiver mostly stalls
        src_gap_pct  = 10;
        rcv_idle_pct = 75;
        for (k = 0; k < dir_rows.size(); k++) begin
            push_item(dir_rows[k].it);
            // rows with a hand-written result replace the modeled one
            if (dir_rows[k].typed) begin
                void'(due_results.pop_back());
                due_results.push_back(dir_rows[k].want);
            end
        end
        run_mix(12);
        drain();

        // phase 2: roles swapped, plus a long receiver hold-off with the ring filling up
        src_gap_pct  = 75;
        rcv_idle_pct = 10;
        overfill_queue();
        drain();
        run_mix(12);
        drain();

        // phase 3: no idling; longest legal frame, then an overlong one
        src_gap_pct  = 0;
        rcv_idle_pct = 0;
        flush_queue();
        send_frame(FM, 1'b0);
        flush_queue();
        send_frame($urandom_range(FM + 1, FM + 2), 1'b1);
        run_mix(6);
        drain();

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
